// ===== design/rycq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycq_pkg
// Shared types and fixed-point coefficients for the RGB to YCbCr 4:2:0
// block converter (BT.601 studio range).
// ----------------------------------------------------------------------------
package rycq_pkg;

    localparam int PIX_W   = 8;
    localparam int HALF_W  = 31;

    // Luma coefficients, 24 fractional bits, all positive
    localparam logic [23:0] LUMA_KR = 24'd4308192;
    localparam logic [23:0] LUMA_KG = 24'd8457888;
    localparam logic [23:0] LUMA_KB = 24'd1642588;
    localparam logic [31:0] LUMA_OFS = 32'd268435456;
    localparam logic [31:0] HALF_OUT = 32'd8388608;

    // Chroma coefficients, 23 fractional bits, signed
    localparam logic signed [23:0] CB_KR = -24'sd1243385;
    localparam logic signed [23:0] CB_KG = -24'sd2441024;
    localparam logic signed [23:0] CB_KB = 24'sd3684408;
    localparam logic signed [23:0] CR_KR = 24'sd3684408;
    localparam logic signed [23:0] CR_KG = -24'sd3085235;
    localparam logic signed [23:0] CR_KB = -24'sd599173;
    localparam logic signed [33:0] CHR_OFS = 34'sd1073741824;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rycq_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [HALF_W-1:0] cb_half;
        logic [HALF_W-1:0] cr_half;
    } rycq_pix_res_t;

endpackage
`default_nettype wire

// ===== design/rgb_to_ycbcr420_quad_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_quad_unit
// Converts a 2x2 block of 8-bit RGB pixels into four BT.601 studio-range
// luma bytes and one averaged Cb and Cr byte (4:2:0).
// ----------------------------------------------------------------------------
// One block is accepted per clock cycle. Each transaction passes an input
// register and a result register, so out_valid rises when the block moves
// from the input register into the result register; the per-pixel constant
// multiplies and the four-way chroma sum sit in the single combinational
// path between the two registers. The pipeline stalls only when the result
// register is held by out_ready low.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_quad_unit
    import rycq_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  tl_red,
    input  wire  [7:0]  tl_green,
    input  wire  [7:0]  tl_blue,
    input  wire  [7:0]  tr_red,
    input  wire  [7:0]  tr_green,
    input  wire  [7:0]  tr_blue,
    input  wire  [7:0]  bl_red,
    input  wire  [7:0]  bl_green,
    input  wire  [7:0]  bl_blue,
    input  wire  [7:0]  br_red,
    input  wire  [7:0]  br_green,
    input  wire  [7:0]  br_blue,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  luma_tl,
    output logic [7:0]  luma_tr,
    output logic [7:0]  luma_bl,
    output logic [7:0]  luma_br,
    output logic [7:0]  chroma_blue,
    output logic [7:0]  chroma_red
);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    rycq_pixel_t   pix_reg [4];
    rycq_pix_res_t pix_res [4];
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    luma_reg [4];
    logic [7:0]    cb_reg;
    logic [7:0]    cr_reg;
    logic          advance;
    logic          s1_load;
    logic [32:0]   cb_sum;
    logic [32:0]   cr_sum;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the accepted block
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            pix_reg[0] <= '{red: tl_red, green: tl_green, blue: tl_blue};
            pix_reg[1] <= '{red: tr_red, green: tr_green, blue: tr_blue};
            pix_reg[2] <= '{red: bl_red, green: bl_green, blue: bl_blue};
            pix_reg[3] <= '{red: br_red, green: br_green, blue: br_blue};
        end
    end

    for (genvar p = 0; p < 4; p++)
    begin : g_pix
        rycq_pixel u_pixel
        (
            .pix (pix_reg[p]),
            .res (pix_res[p])
        );
    end

    always_comb
    begin
        cb_sum = 33'(pix_res[0].cb_half) + 33'(pix_res[1].cb_half)
               + 33'(pix_res[2].cb_half) + 33'(pix_res[3].cb_half)
               + 33'(HALF_OUT);
        cr_sum = 33'(pix_res[0].cr_half) + 33'(pix_res[1].cr_half)
               + 33'(pix_res[2].cr_half) + 33'(pix_res[3].cr_half)
               + 33'(HALF_OUT);
    end

    // advance the result register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                luma_reg[i] <= pix_res[i].luma;
            end
            cb_reg <= cb_sum[31:24];
            cr_reg <= cr_sum[31:24];
        end
    end

    assign out_valid   = out_valid_reg;
    assign luma_tl     = luma_reg[0];
    assign luma_tr     = luma_reg[1];
    assign luma_bl     = luma_reg[2];
    assign luma_br     = luma_reg[3];
    assign chroma_blue = cb_reg;
    assign chroma_red  = cr_reg;

endmodule
`default_nettype wire

// ===== design/rycq_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycq_pixel
// Per-pixel conversion: rounded luma byte and the halved, offset Cb and Cr
// contributions that the block sums for its subsampled chroma.
// ----------------------------------------------------------------------------
module rycq_pixel
    import rycq_pkg::*;
(
    input  var rycq_pixel_t   pix,
    output var rycq_pix_res_t res
);

    logic [31:0]        y_sum;
    logic signed [8:0]  r_s;
    logic signed [8:0]  g_s;
    logic signed [8:0]  b_s;
    logic signed [32:0] cb_pr;
    logic signed [32:0] cb_pg;
    logic signed [32:0] cb_pb;
    logic signed [32:0] cr_pr;
    logic signed [32:0] cr_pg;
    logic signed [32:0] cr_pb;
    logic signed [33:0] cb_full;
    logic signed [33:0] cr_full;
    logic [31:0]        cb_inc;
    logic [31:0]        cr_inc;

    always_comb
    begin
        y_sum = 32'(pix.red) * 32'(LUMA_KR)
              + 32'(pix.green) * 32'(LUMA_KG)
              + 32'(pix.blue) * 32'(LUMA_KB)
              + LUMA_OFS + HALF_OUT;

        r_s = $signed({1'b0, pix.red});
        g_s = $signed({1'b0, pix.green});
        b_s = $signed({1'b0, pix.blue});

        cb_pr = r_s * CB_KR;
        cb_pg = g_s * CB_KG;
        cb_pb = b_s * CB_KB;
        cr_pr = r_s * CR_KR;
        cr_pg = g_s * CR_KG;
        cr_pb = b_s * CR_KB;

        cb_full = 34'(cb_pr) + 34'(cb_pg) + 34'(cb_pb) + CHR_OFS;
        cr_full = 34'(cr_pr) + 34'(cr_pg) + 34'(cr_pb) + CHR_OFS;

        // round half up, value stays in [0, 2^31)
        cb_inc = {1'b0, cb_full[30:0]} + 32'd1;
        cr_inc = {1'b0, cr_full[30:0]} + 32'd1;

        res.luma    = y_sum[31:24];
        res.cb_half = cb_inc[31:1];
        res.cr_half = cr_inc[31:1];
    end

endmodule
`default_nettype wire

// ===== test/ycbcr_quad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_quad_checker
// Watches both channels of the RGB to YCbCr 4:2:0 quad converter, predicts
// the four luma bytes and the averaged chroma pair for every accepted block,
// and compares each accepted result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module ycbcr_quad_checker
    import rycq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  tl_red,
    input  logic [7:0]  tl_green,
    input  logic [7:0]  tl_blue,
    input  logic [7:0]  tr_red,
    input  logic [7:0]  tr_green,
    input  logic [7:0]  tr_blue,
    input  logic [7:0]  bl_red,
    input  logic [7:0]  bl_green,
    input  logic [7:0]  bl_blue,
    input  logic [7:0]  br_red,
    input  logic [7:0]  br_green,
    input  logic [7:0]  br_blue,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  luma_tl,
    input  logic [7:0]  luma_tr,
    input  logic [7:0]  luma_bl,
    input  logic [7:0]  luma_br,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    output int          outstanding,
    output int          fail_count
);

    localparam longint Y_KR      = 4308192;
    localparam longint Y_KG      = 8457888;
    localparam longint Y_KB      = 1642588;
    localparam longint Y_OFFSET  = 64'd268435456;
    localparam longint U_KR      = -1243385;
    localparam longint U_KG      = -2441024;
    localparam longint U_KB      = 3684408;
    localparam longint V_KR      = 3684408;
    localparam longint V_KG      = -3085235;
    localparam longint V_KB      = -599173;
    localparam longint C_OFFSET  = 64'd1073741824;
    localparam longint OUT_ROUND = 64'd8388608;

    typedef struct packed {
        logic [3:0][7:0] luma;
        logic [7:0]      cb;
        logic [7:0]      cr;
    } ycc_block_t;

    ycc_block_t ycc_expected_q [$];
    ycc_block_t want;
    int         mismatch_count = 0;

    function automatic ycc_block_t convert_block(input rycq_pixel_t p0, p1, p2, p3);
        rycq_pixel_t quad [4];
        longint      r;
        longint      g;
        longint      b;
        longint      y;
        longint      cb_sum;
        longint      cr_sum;
        ycc_block_t  res;
        quad[0] = p0;
        quad[1] = p1;
        quad[2] = p2;
        quad[3] = p3;
        cb_sum = 0;
        cr_sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            r = longint'(quad[i].red);
            g = longint'(quad[i].green);
            b = longint'(quad[i].blue);
            y = Y_KR * r + Y_KG * g + Y_KB * b + Y_OFFSET + OUT_ROUND;
            res.luma[i] = 8'(y >>> 24);
            cb_sum += (U_KR * r + U_KG * g + U_KB * b + C_OFFSET + 1) >>> 1;
            cr_sum += (V_KR * r + V_KG * g + V_KB * b + C_OFFSET + 1) >>> 1;
        end
        res.cb = 8'((cb_sum + OUT_ROUND) >>> 24);
        res.cr = 8'((cr_sum + OUT_ROUND) >>> 24);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (ycc_expected_q.size() == 0)
                begin
                    $error("result transaction with none pending: luma_tl %0d chroma_blue %0d",
                           luma_tl, chroma_blue);
                    mismatch_count++;
                end
                else
                begin
                    want = ycc_expected_q.pop_front();
                    check_field("luma_tl", want.luma[0], luma_tl);
                    check_field("luma_tr", want.luma[1], luma_tr);
                    check_field("luma_bl", want.luma[2], luma_bl);
                    check_field("luma_br", want.luma[3], luma_br);
                    check_field("chroma_blue", want.cb, chroma_blue);
                    check_field("chroma_red", want.cr, chroma_red);
                end
            end
            if (in_valid && in_ready)
                ycc_expected_q.push_back(convert_block({tl_red, tl_green, tl_blue},
                                                       {tr_red, tr_green, tr_blue},
                                                       {bl_red, bl_green, bl_blue},
                                                       {br_red, br_green, br_blue}));
            outstanding <= ycc_expected_q.size();
            fail_count  <= mismatch_count;
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives 2x2 RGB blocks into the YCbCr 4:2:0 quad converter: solid and mixed
// primaries first, then random, extreme-biased and smooth blocks under random
// idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import rycq_pkg::*;

    localparam int RANDOM_BLOCKS = 934;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PCT      = 18;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  tl_red;
    logic [7:0]  tl_green;
    logic [7:0]  tl_blue;
    logic [7:0]  tr_red;
    logic [7:0]  tr_green;
    logic [7:0]  tr_blue;
    logic [7:0]  bl_red;
    logic [7:0]  bl_green;
    logic [7:0]  bl_blue;
    logic [7:0]  br_red;
    logic [7:0]  br_green;
    logic [7:0]  br_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  luma_tl;
    logic [7:0]  luma_tr;
    logic [7:0]  luma_bl;
    logic [7:0]  luma_br;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    int          outstanding;
    int          fail_count;
    int          cycle_count;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          hold_req;
    rycq_pixel_t quad [4];
    rycq_pixel_t palette [8];

    rgb_to_ycbcr420_quad_unit u_dut (.*);

    ycbcr_quad_checker u_checker (.*);

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_block(input rycq_pixel_t tl, tr, bl, br);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {tl_red, tl_green, tl_blue} <= tl;
        {tr_red, tr_green, tr_blue} <= tr;
        {bl_red, bl_green, bl_blue} <= bl;
        {br_red, br_green, br_blue} <= br;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_level(input bit biased);
        if (biased && $urandom_range(2) != 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic rycq_pixel_t near_color(input rycq_pixel_t base);
        rycq_pixel_t res;
        int          v;
        for (int k = 0; k < 3; k++)
        begin
            v = int'(base[k*8 +: 8]) + int'($urandom_range(24)) - 12;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            res[k*8 +: 8] = 8'(v);
        end
        return res;
    endfunction

    initial
    begin
        rycq_pixel_t base;
        int          mode;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        {tl_red, tl_green, tl_blue} = '0;
        {tr_red, tr_green, tr_blue} = '0;
        {bl_red, bl_green, bl_blue} = '0;
        {br_red, br_green, br_blue} = '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        palette[0] = {8'd0,   8'd0,   8'd0};
        palette[1] = {8'd255, 8'd255, 8'd255};
        palette[2] = {8'd255, 8'd0,   8'd0};
        palette[3] = {8'd0,   8'd255, 8'd0};
        palette[4] = {8'd0,   8'd0,   8'd255};
        palette[5] = {8'd0,   8'd255, 8'd255};
        palette[6] = {8'd255, 8'd0,   8'd255};
        palette[7] = {8'd255, 8'd255, 8'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (palette[c])
            send_block(palette[c], palette[c], palette[c], palette[c]);
        send_block(palette[2], palette[3], palette[4], palette[1]);
        send_block(palette[1], palette[0], palette[0], palette[1]);
        send_block(palette[0], palette[1], palette[1], palette[0]);
        send_block(palette[7], palette[5], palette[6], palette[0]);
        send_block(palette[1], palette[1], palette[1], palette[0]);
        send_block(palette[0], palette[0], palette[0], palette[1]);
        send_block({8'hAA, 8'h55, 8'hAA}, {8'h55, 8'hAA, 8'h55},
                   {8'h01, 8'h02, 8'h04}, {8'hFE, 8'hFD, 8'hFB});
        send_block({8'd1, 8'd1, 8'd1}, {8'd254, 8'd254, 8'd254},
                   {8'd255, 8'd0, 8'd255}, {8'd0, 8'd255, 8'd0});

        for (int i = 0; i < RANDOM_BLOCKS; i++)
        begin
            if (i == 100)
                hold_req = 1'b1;
            src_idle_on  = !(i >= 300 && i < 500);
            sink_idle_on = src_idle_on;
            if (i == 650)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            mode = $urandom_range(3);
            base = {rand_level(1'b0), rand_level(1'b0), rand_level(1'b0)};
            for (int k = 0; k < 4; k++)
            begin
                if (mode >= 2)
                    quad[k] = near_color(base);
                else
                    quad[k] = {rand_level(mode == 1), rand_level(mode == 1),
                               rand_level(mode == 1)};
            end
            send_block(quad[0], quad[1], quad[2], quad[3]);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rgb_to_ycbcr420_quad_unit test passed");
        else
            $display("rgb_to_ycbcr420_quad_unit test failed");
        $finish;
    end

    initial
    begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
            @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rgb_to_ycbcr420_quad_unit test failed");
        $finish;
    end

endmodule
